@@ hdl/efd_pkg.sv @@
// ----------------------------------------------------------------------------
// efd_pkg: shared types and constants of the escaped frame deframer
// Mode and status codes, register indexes, configuration and result
// records, and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package efd_pkg;

  localparam int unsigned BODY_DEPTH   = 1024;
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned HDR_IDX_W    = $clog2(HEADER_BYTES);

  // Largest body length the counters can carry
  localparam int unsigned BODY_CAP = 1024;
  localparam logic [10:0] BODY_LIMIT =
      11'((BODY_DEPTH < BODY_CAP) ? BODY_DEPTH : BODY_CAP);

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_RESIDUE = 16'h0000;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  // Minimum body lengths: header plus CRC, with and without timestamp
  localparam logic [10:0] MIN_LEN    = 11'(8 + 2);
  localparam logic [10:0] MIN_LEN_TS = 11'(8 + 4 + 2);
  localparam logic [10:0] HDR_LEN    = 11'd8;
  localparam logic [10:0] HDR_LEN_TS = 11'd12;
  localparam logic [10:0] CRC_LEN    = 11'd2;

  typedef enum logic [1:0] {
    MODE_HUNT0,
    MODE_HUNT1,
    MODE_BODY
  } mode_e;

  typedef enum logic [2:0] {
    STAT_OK,
    STAT_SHORT,
    STAT_CRC,
    STAT_BAD_ESC,
    STAT_OVERFLOW,
    STAT_LEN_MISMATCH
  } status_e;

  typedef enum logic [2:0] {
    CFG_START_FIRST,
    CFG_START_SECOND,
    CFG_END_MARK,
    CFG_ESC_MARK,
    CFG_ESC_END_CODE,
    CFG_ESC_ESC_CODE,
    CFG_TS_MASK,
    CFG_MAX_LEN
  } cfg_idx_e;

  typedef enum logic {
    KIND_DATA,
    KIND_END
  } kind_e;

  typedef struct packed {
    logic [7:0]  start_first;
    logic [7:0]  start_second;
    logic [7:0]  end_mark;
    logic [7:0]  esc_mark;
    logic [7:0]  esc_end_code;
    logic [7:0]  esc_esc_code;
    logic [7:0]  ts_mask;
    logic [10:0] max_len;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [9:0]  byte_index;
    logic [2:0]  status;
    logic [10:0] frame_length;
    logic [7:0]  version;
    logic [7:0]  flags;
    logic [15:0] seq_num;
    logic [7:0]  command;
    logic [7:0]  channel;
    logic [15:0] declared_len;
    logic [31:0] timestamp;
  } res_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      v = v[15] ? ((v << 1) ^ CRC_POLY) : (v << 1);
    end
    return v;
  endfunction

endpackage

@@ hdl/efd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// efd_cfg_regs: configuration register bank
// Write-only registers loaded from the plain write port.
// ----------------------------------------------------------------------------
module efd_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [10:0]        cfg_data_i,
  output efd_pkg::cfg_t      cfg_o
);

  efd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (efd_pkg::cfg_idx_e'(cfg_idx_i))
        efd_pkg::CFG_START_FIRST:  cfg_d.start_first  = cfg_data_i[7:0];
        efd_pkg::CFG_START_SECOND: cfg_d.start_second = cfg_data_i[7:0];
        efd_pkg::CFG_END_MARK:     cfg_d.end_mark     = cfg_data_i[7:0];
        efd_pkg::CFG_ESC_MARK:     cfg_d.esc_mark     = cfg_data_i[7:0];
        efd_pkg::CFG_ESC_END_CODE: cfg_d.esc_end_code = cfg_data_i[7:0];
        efd_pkg::CFG_ESC_ESC_CODE: cfg_d.esc_esc_code = cfg_data_i[7:0];
        efd_pkg::CFG_TS_MASK:      cfg_d.ts_mask      = cfg_data_i[7:0];
        efd_pkg::CFG_MAX_LEN:      cfg_d.max_len      = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_first  <= 8'hAA;
      cfg_q.start_second <= 8'h55;
      cfg_q.end_mark     <= 8'h7E;
      cfg_q.esc_mark     <= 8'h7D;
      cfg_q.esc_end_code <= 8'h5E;
      cfg_q.esc_esc_code <= 8'h5D;
      cfg_q.ts_mask      <= 8'h01;
      cfg_q.max_len      <= 11'd1024;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/efd_parser.sv @@
// ----------------------------------------------------------------------------
// efd_parser: start hunt, unescape, CRC and header capture
// Processes one raw byte per accepted transfer and forms at most one result.
// ----------------------------------------------------------------------------
module efd_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  efd_pkg::cfg_t      cfg_i,
  input  logic               accept_i,
  input  logic [7:0]         byte_i,
  output logic               push_o,
  output efd_pkg::res_t      res_o
);

  efd_pkg::mode_e mode_q, mode_d;
  logic           esc_q, esc_d;
  logic [15:0]    crc_q, crc_d;
  logic [10:0]    cnt_q, cnt_d;
  logic [7:0]     hdr_q [efd_pkg::HEADER_BYTES];

  logic [7:0]     ub;
  logic           take;
  logic           is_end;
  logic           emit_data;
  logic           hdr_we;
  logic [2:0]     status;
  logic [2:0]     end_st;
  logic [10:0]    limit;
  logic           ts_flag;
  logic [10:0]    pay_cnt;

  assign limit   = (cfg_i.max_len > efd_pkg::BODY_LIMIT) ? efd_pkg::BODY_LIMIT : cfg_i.max_len;
  assign ts_flag = (hdr_q[1] & cfg_i.ts_mask) != 8'h00;
  assign pay_cnt = cnt_q - efd_pkg::CRC_LEN - (ts_flag ? efd_pkg::HDR_LEN_TS : efd_pkg::HDR_LEN);

  // Status of a frame closed by an end mark
  always_comb begin
    if (cnt_q < efd_pkg::MIN_LEN) begin
      end_st = efd_pkg::STAT_SHORT;
    end else if (crc_q != efd_pkg::CRC_RESIDUE) begin
      end_st = efd_pkg::STAT_CRC;
    end else if (ts_flag && (cnt_q < efd_pkg::MIN_LEN_TS)) begin
      end_st = efd_pkg::STAT_LEN_MISMATCH;
    end else if ({5'b0, pay_cnt} != {hdr_q[6], hdr_q[7]}) begin
      end_st = efd_pkg::STAT_LEN_MISMATCH;
    end else begin
      end_st = efd_pkg::STAT_OK;
    end
  end

  always_comb begin
    mode_d    = mode_q;
    esc_d     = esc_q;
    crc_d     = crc_q;
    cnt_d     = cnt_q;
    ub        = byte_i;
    take      = 1'b0;
    is_end    = 1'b0;
    emit_data = 1'b0;
    hdr_we    = 1'b0;
    status    = efd_pkg::STAT_OK;
    if (accept_i) begin
      case (mode_q)
        efd_pkg::MODE_HUNT0: begin
          if (byte_i == cfg_i.start_first) mode_d = efd_pkg::MODE_HUNT1;
        end
        efd_pkg::MODE_HUNT1: begin
          if (byte_i == cfg_i.start_second) begin
            mode_d = efd_pkg::MODE_BODY;
            esc_d  = 1'b0;
            crc_d  = efd_pkg::CRC_INIT;
            cnt_d  = '0;
          end else if (byte_i != cfg_i.start_first) begin
            mode_d = efd_pkg::MODE_HUNT0;
          end
        end
        efd_pkg::MODE_BODY: begin
          if (!esc_q && (byte_i == cfg_i.end_mark)) begin
            is_end = 1'b1;
            status = end_st;
          end else if (esc_q) begin
            esc_d = 1'b0;
            if (byte_i == cfg_i.esc_end_code) begin
              ub   = cfg_i.end_mark;
              take = 1'b1;
            end else if (byte_i == cfg_i.esc_esc_code) begin
              ub   = cfg_i.esc_mark;
              take = 1'b1;
            end else begin
              is_end = 1'b1;
              status = efd_pkg::STAT_BAD_ESC;
            end
          end else if (byte_i == cfg_i.esc_mark) begin
            esc_d = 1'b1;
          end else begin
            take = 1'b1;
          end
        end
        default: mode_d = efd_pkg::MODE_HUNT0;
      endcase
    end

    if (take) begin
      if (cnt_q >= limit) begin
        is_end = 1'b1;
        status = efd_pkg::STAT_OVERFLOW;
      end else begin
        emit_data = 1'b1;
        crc_d     = efd_pkg::crc16_byte(crc_q, ub);
        cnt_d     = cnt_q + 11'd1;
        hdr_we    = cnt_q < 11'(efd_pkg::HEADER_BYTES);
      end
    end

    // Any frame end drops back to the start hunt
    if (is_end) begin
      mode_d = efd_pkg::MODE_HUNT0;
      esc_d  = 1'b0;
      crc_d  = efd_pkg::CRC_INIT;
      cnt_d  = '0;
    end
  end

  always_comb begin
    res_o = '0;
    if (emit_data) begin
      res_o.kind       = efd_pkg::KIND_DATA;
      res_o.data_byte  = ub;
      res_o.byte_index = cnt_q[9:0];
    end else if (is_end) begin
      res_o.kind         = efd_pkg::KIND_END;
      res_o.status       = status;
      res_o.frame_length = cnt_q;
      if (cnt_q >= efd_pkg::HDR_LEN) begin
        res_o.version      = hdr_q[0];
        res_o.flags        = hdr_q[1];
        res_o.seq_num      = {hdr_q[2], hdr_q[3]};
        res_o.command      = hdr_q[4];
        res_o.channel      = hdr_q[5];
        res_o.declared_len = {hdr_q[6], hdr_q[7]};
        if (ts_flag && (cnt_q >= efd_pkg::HDR_LEN_TS)) begin
          res_o.timestamp = {hdr_q[8], hdr_q[9], hdr_q[10], hdr_q[11]};
        end
      end
    end
  end

  assign push_o = emit_data | is_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= efd_pkg::MODE_HUNT0;
      esc_q  <= 1'b0;
      crc_q  <= efd_pkg::CRC_INIT;
      cnt_q  <= '0;
    end else begin
      mode_q <= mode_d;
      esc_q  <= esc_d;
      crc_q  <= crc_d;
      cnt_q  <= cnt_d;
    end
  end

  // Header bytes hold no reset; each is written before it is read
  always_ff @(posedge clk_i) begin
    if (hdr_we) hdr_q[cnt_q[efd_pkg::HDR_IDX_W-1:0]] <= ub;
  end

endmodule

@@ hdl/efd_out_buf.sv @@
// ----------------------------------------------------------------------------
// efd_out_buf: result register with skid stage
// Holds results for the master side so input transfers continue while a
// result waits.
// ----------------------------------------------------------------------------
module efd_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  efd_pkg::res_t      res_i,
  output logic               ready_o,
  output logic               valid_o,
  output efd_pkg::res_t      res_o,
  input  logic               ready_i
);

  logic          out_vld_q, out_vld_d;
  logic          skid_vld_q, skid_vld_d;
  efd_pkg::res_t out_q, out_d;
  efd_pkg::res_t skid_q, skid_d;
  logic          pop;

  assign pop     = out_vld_q & ready_i;
  assign ready_o = ~skid_vld_q;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (!out_vld_q || pop) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = push_i;
        skid_d     = res_i;
      end else begin
        out_d     = res_i;
        out_vld_d = push_i;
      end
    end else if (push_i) begin
      // Output stalled: park the new result
      skid_d     = res_i;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign valid_o = out_vld_q;
  assign res_o   = out_q;

endmodule

@@ hdl/escaped_frame_deframer_crc16_core.sv @@
// Each result is registered in the output buffer before it appears on the
// master side. Throughput: one byte per cycle while the output buffer has
// room, set by the combinational byte CRC update and unescape in the parser;
// a two-entry output buffer keeps input transfers going while a result waits.
// Reset: hunting for the start mark, CRC 0xFFFF, count 0, registers at their
// defaults; header bytes are not cleared.
// ----------------------------------------------------------------------------
// escaped_frame_deframer_crc16_core: byte-stuffed frame deframer
// Hunts the start mark, removes escapes, checks CRC-16 and reports frame end
// with status and decoded header fields.
// ----------------------------------------------------------------------------
module escaped_frame_deframer_crc16_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [10:0]   cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // [7:0] rx_byte
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [7:0] data_byte, [17:8] byte_index, [20:18] status, [31:21] frame_length,
  // [39:32] version, [47:40] flags, [63:48] seq_num, [71:64] command,
  // [79:72] channel, [95:80] declared_len, [127:96] timestamp
  output logic [127:0]  m_axis_tdata,
  output logic [0:0]    m_axis_tuser    // [0] result_kind
);

  efd_pkg::cfg_t cfg;
  efd_pkg::res_t res_new;
  efd_pkg::res_t res_out;
  logic          push;
  logic          accept;

  assign accept = s_axis_tvalid & s_axis_tready;

  efd_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  efd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .push_o   (push),
    .res_o    (res_new)
  );

  efd_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (res_new),
    .ready_o (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .res_o   (res_out),
    .ready_i (m_axis_tready)
  );

  assign m_axis_tuser = res_out.kind;
  assign m_axis_tdata = {res_out.timestamp,
                         res_out.declared_len,
                         res_out.channel,
                         res_out.command,
                         res_out.seq_num,
                         res_out.flags,
                         res_out.version,
                         res_out.frame_length,
                         res_out.status,
                         res_out.byte_index,
                         res_out.data_byte};

endmodule
